/* hw/rtl/sazc_pkg.sv */
`timescale 1ns / 1ps

package sazc_pkg;

  localparam int NUM_CLASSES     = 20;
  localparam int ANGLE_FRAC_BITS = 15;
  localparam int TABLE_LEN       = 20;
  localparam int MAX_CLASS       = (NUM_CLASSES < TABLE_LEN) ? NUM_CLASSES : TABLE_LEN;
  localparam int CLS_IDX_W       = $clog2(TABLE_LEN);

  localparam int CLS_W = 5;
  localparam int COS_W = 16;
  localparam int OUT_W = 16;
  localparam int ST_W  = 2;

  localparam logic [CLS_W-1:0] OCEAN_CLASS = 5'd17;
  localparam logic [COS_W-1:0] COS_ONE     = 16'd32768;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_CLASS = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // square root of (1 - c^2) in Q.60 / Q.30
  localparam int RAD_W      = 31;
  localparam int REM_W      = 62;
  localparam int ROOT_W     = 31;
  localparam int ROOT_STEPS = 31;
  localparam logic [32:0] RAD_ONE = 33'h1 << 30;

  // angle recovery, Q.30
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_Q     = 30;
  localparam int CW           = 34;
  localparam int ZW           = 33;

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021687,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
  };

  // angle powers
  localparam int S_W  = ANGLE_FRAC_BITS + 2;
  localparam int S2_W = ANGLE_FRAC_BITS + 4;
  localparam int S3_W = ANGLE_FRAC_BITS + 6;
  localparam logic [S_W-1:0] SZA_MAX = S_W'((64'd1571 << ANGLE_FRAC_BITS) / 64'd1000);

  // polynomial coefficients, Q.24
  localparam int CONST_W = 24;
  localparam int TP_W    = CONST_W + S3_W;
  localparam int T_W     = 32;
  localparam int G_W     = 36;
  localparam int B_W     = 15;

  localparam logic [CONST_W-1:0] G1_C2 = 24'd1190964;
  localparam logic [CONST_W-1:0] G1_C3 = 24'd5160470;
  localparam logic [CONST_W-1:0] G2_C2 = 24'd2790286;
  localparam logic [CONST_W-1:0] G2_C3 = 24'd701959;

  localparam int G1_C0   = 127071;
  localparam int G2_C0   = 21557196;
  localparam int G1N     = 4493106;
  localparam int G2N_NEG = 23810225;
  localparam int G1M     = 1047569;
  localparam int G2M_NEG = 22677763;

  localparam logic signed [G_W-1:0] E1_OFS  = G_W'(-(G1_C0 + G1N));
  localparam logic signed [G_W-1:0] E2_OFS  = G_W'(G2N_NEG - G2_C0);
  localparam logic signed [G_W-1:0] ONE_Q24 = G_W'(1 << 24);

  localparam logic [B_W-1:0] B1_TAB [TABLE_LEN] = '{
    15'd6029, 15'd6029, 15'd3408, 15'd4456, 15'd4391, 15'd6947, 15'd8389,
    15'd6226, 15'd6554, 15'd8913, 15'd22938, 15'd8847, 15'd6554, 15'd8847,
    15'd6554, 15'd8847, 15'd6554, 15'd6554, 15'd6554, 15'd6554
  };

  localparam logic [B_W-1:0] B2_TAB [TABLE_LEN] = '{
    15'd5046, 15'd5046, 15'd6554, 15'd6554, 15'd5636, 15'd4063, 15'd3670,
    15'd5898, 15'd3801, 15'd1180, 15'd6554, 15'd1573, 15'd6554, 15'd1573,
    15'd6554, 15'd328, 15'd6554, 15'd6554, 15'd6554, 15'd6554
  };

  // divider
  localparam int N_W = 48;
  localparam int D_W = 32;
  localparam int Q_W = OUT_W;

  localparam logic [15:0]    OCEAN_2D  = 16'd53740;
  localparam logic [D_W-1:0] DEN_BASE  = 32'h8000_0000;
  localparam logic [N_W-1:0] OCEAN_NUM = 48'd92406 << 29;

  typedef logic [D_W-1:0] dtab_t [TABLE_LEN];

  function automatic dtab_t calc_dtab();
    dtab_t t;
    longint p1;
    longint p2;
    longint d;
    for (int k = 0; k < TABLE_LEN; k++) begin
      p1 = -((longint'(B1_TAB[k]) * longint'(G1N - G1M)) >>> 16);
      p2 = (longint'(B2_TAB[k]) * longint'(G2N_NEG - G2M_NEG)) >>> 16;
      d  = longint'(1 << 24) + p1 + p2;
      if (d < 1) d = 1;
      t[k] = D_W'(d);
    end
    return t;
  endfunction

  localparam dtab_t D_TAB = calc_dtab();

  function automatic logic class_in_table(logic [CLS_W-1:0] cls);
    return (cls >= 5'd1) && (cls <= CLS_W'(TABLE_LEN));
  endfunction

  function automatic logic [B_W-1:0] b1_of(logic [CLS_W-1:0] cls);
    logic [CLS_IDX_W-1:0] idx;
    idx = CLS_IDX_W'(cls - 5'd1);
    if (class_in_table(cls)) return B1_TAB[idx];
    return '0;
  endfunction

  function automatic logic [B_W-1:0] b2_of(logic [CLS_W-1:0] cls);
    logic [CLS_IDX_W-1:0] idx;
    idx = CLS_IDX_W'(cls - 5'd1);
    if (class_in_table(cls)) return B2_TAB[idx];
    return '0;
  endfunction

  function automatic logic [D_W-1:0] d_of(logic [CLS_W-1:0] cls);
    logic [CLS_IDX_W-1:0] idx;
    idx = CLS_IDX_W'(cls - 5'd1);
    if (class_in_table(cls)) return D_TAB[idx];
    return D_W'(1);
  endfunction

  typedef struct packed {
    logic             valid;
    logic [CLS_W-1:0] cls;
    logic [COS_W-1:0] cos;
    logic [ST_W-1:0]  status;
    logic             zero;
  } side_t;

endpackage

/* hw/rtl/sazc_isqrt.sv */
`timescale 1ns / 1ps

module sazc_isqrt
  import sazc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ce,
  input  side_t             side_i,
  output side_t             side_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [2*COS_W-1:0] csq;
  logic [RAD_W-1:0]   rad_r;
  side_t              side0_r;

  logic [REM_W-1:0]  rem_r [ROOT_STEPS-1];
  logic [ROOT_W-1:0] q_r   [ROOT_STEPS];
  side_t             sd_r  [ROOT_STEPS];

  assign csq = side_i.cos * side_i.cos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side0_r.valid <= 1'b0;
    end else if (ce) begin
      side0_r <= side_i;
      rad_r   <= RAD_W'(RAD_ONE - 33'(csq));
    end
  end

  // one root bit per stage, MSB first
  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
    localparam int I = ROOT_STEPS - 1 - j;
    logic [REM_W-1:0]  rc;
    logic [REM_W-1:0]  term;
    logic [ROOT_W-1:0] qc;
    side_t             sc;
    logic              take;

    if (j == 0) begin : g_first
      assign rc = {1'b0, rad_r, 30'b0};
      assign qc = '0;
      assign sc = side0_r;
    end else begin : g_next
      assign rc = rem_r[j-1];
      assign qc = q_r[j-1];
      assign sc = sd_r[j-1];
    end

    assign term = (REM_W'(qc) << (I + 1)) + (REM_W'(1) << (2 * I));
    assign take = rc >= term;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[j].valid <= 1'b0;
      end else if (ce) begin
        sd_r[j] <= sc;
        q_r[j]  <= take ? (qc | (ROOT_W'(1) << I)) : qc;
      end
    end

    if (j < ROOT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[j] <= take ? (rc - term) : rc;
        end
      end
    end
  end

  assign side_o = sd_r[ROOT_STEPS-1];
  assign root_o = q_r[ROOT_STEPS-1];

endmodule

/* hw/rtl/sazc_cordic.sv */
`timescale 1ns / 1ps

module sazc_cordic
  import sazc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ce,
  input  side_t                side_i,
  input  logic [ROOT_W-1:0]    root_i,
  output side_t                side_o,
  output logic signed [ZW-1:0] z_o
);

  logic signed [CW-1:0] x_r  [CORDIC_STEPS];
  logic signed [CW-1:0] y_r  [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r  [CORDIC_STEPS];
  side_t                sd_r [CORDIC_STEPS];

  // vectoring mode: drive y to zero, accumulate angle in z
  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_step
    logic signed [CW-1:0] xc;
    logic signed [CW-1:0] yc;
    logic signed [ZW-1:0] zc;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] ang;
    side_t                sc;
    logic                 pos;

    if (j == 0) begin : g_first
      assign xc = $signed(CW'({side_i.cos, 15'b0}));
      assign yc = $signed(CW'(root_i));
      assign zc = '0;
      assign sc = side_i;
    end else begin : g_next
      assign xc = x_r[j-1];
      assign yc = y_r[j-1];
      assign zc = z_r[j-1];
      assign sc = sd_r[j-1];
    end

    assign xs  = xc >>> j;
    assign ys  = yc >>> j;
    assign ang = $signed(ZW'(ATAN_TAB[j]));
    assign pos = !yc[CW-1] && (yc != '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[j].valid <= 1'b0;
      end else if (ce) begin
        sd_r[j] <= sc;
        x_r[j]  <= pos ? (xc + ys) : (xc - ys);
        y_r[j]  <= pos ? (yc - xs) : (yc + xs);
        z_r[j]  <= pos ? (zc + ang) : (zc - ang);
      end
    end
  end

  assign side_o = sd_r[CORDIC_STEPS-1];
  assign z_o    = z_r[CORDIC_STEPS-1];

endmodule

/* hw/rtl/sazc_poly.sv */
`timescale 1ns / 1ps

module sazc_poly
  import sazc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ce,
  input  side_t                 side_i,
  input  logic signed [ZW-1:0]  z_i,
  output side_t                 side_o,
  output logic signed [G_W-1:0] n_o,
  output logic [D_W-1:0]        den_o
);

  function automatic logic signed [G_W-1:0] smul16(logic signed [G_W-1:0] e,
                                                   logic [B_W-1:0] b);
    logic [G_W-1:0]     mag;
    logic [G_W+B_W-1:0] prod;
    logic [G_W-1:0]     q;
    mag  = e[G_W-1] ? G_W'(-e) : G_W'(e);
    prod = mag * b;
    q    = G_W'(prod >> 16);
    return e[G_W-1] ? -$signed(q) : $signed(q);
  endfunction

  side_t sd1_nxt;
  side_t sd1_r, sd2_r, sd3_r, sd4_r, sd5_r, sd6_r, sd7_r;

  logic [31:0]  zpos;
  logic [S_W-1:0] s;
  logic [S_W-1:0] s1_r, s2s_r;
  logic [2*S_W-1:0] sq;
  logic [S2_W-1:0] s2_2_r, s2_3_r;
  logic [S2_W+S_W-1:0] cube;
  logic [S3_W-1:0] s3_3_r;

  logic [TP_W-1:0] m12, m13, m22, m23;
  logic [T_W-1:0]  t12_r, t13_r, t22_r, t23_r;

  logic signed [G_W-1:0] e1_r, e2_r, p1_r, p2_r, n_r;
  logic [D_W-1:0]        den5_r, den6_r, den7_r;

  assign zpos = z_i[ZW-1] ? '0 : z_i[ZW-2:0];
  assign s    = S_W'(zpos >> (CORDIC_Q - ANGLE_FRAC_BITS));

  always_comb begin
    sd1_nxt = side_i;
    if (side_i.status == ST_OK && side_i.cls != OCEAN_CLASS && s > SZA_MAX) begin
      sd1_nxt.status = ST_RANGE;
    end
  end

  assign sq   = s1_r * s1_r;
  assign cube = s2_2_r * s2s_r;
  assign m12  = G1_C2 * s2_3_r;
  assign m13  = G1_C3 * s3_3_r;
  assign m22  = G2_C2 * s2_3_r;
  assign m23  = G2_C3 * s3_3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd1_r.valid <= 1'b0;
      sd2_r.valid <= 1'b0;
      sd3_r.valid <= 1'b0;
      sd4_r.valid <= 1'b0;
      sd5_r.valid <= 1'b0;
      sd6_r.valid <= 1'b0;
      sd7_r.valid <= 1'b0;
    end else if (ce) begin
      sd1_r <= sd1_nxt;
      sd2_r <= sd1_r;
      sd3_r <= sd2_r;
      sd4_r <= sd3_r;
      sd5_r <= sd4_r;
      sd6_r <= sd5_r;
      sd7_r <= sd6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_r   <= s;
      s2s_r  <= s1_r;
      s2_2_r <= S2_W'(sq >> ANGLE_FRAC_BITS);
      s2_3_r <= s2_2_r;
      s3_3_r <= S3_W'(cube >> ANGLE_FRAC_BITS);
      t12_r  <= T_W'(m12 >> ANGLE_FRAC_BITS);
      t13_r  <= T_W'(m13 >> ANGLE_FRAC_BITS);
      t22_r  <= T_W'(m22 >> ANGLE_FRAC_BITS);
      t23_r  <= T_W'(m23 >> ANGLE_FRAC_BITS);
      e1_r   <= $signed(G_W'(t13_r)) - $signed(G_W'(t12_r)) + E1_OFS;
      e2_r   <= $signed(G_W'(t23_r)) - $signed(G_W'(t22_r)) + E2_OFS;
      den5_r <= DEN_BASE + D_W'(OCEAN_2D * sd4_r.cos);
      p1_r   <= smul16(e1_r, b1_of(sd5_r.cls));
      p2_r   <= smul16(e2_r, b2_of(sd5_r.cls));
      den6_r <= den5_r;
      n_r    <= ONE_Q24 + p1_r + p2_r;
      den7_r <= den6_r;
    end
  end

  assign side_o = sd7_r;
  assign n_o    = n_r;
  assign den_o  = den7_r;

endmodule

/* hw/rtl/sazc_div.sv */
`timescale 1ns / 1ps

module sazc_div
  import sazc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ce,
  input  side_t                 side_i,
  input  logic signed [G_W-1:0] n_i,
  input  logic [D_W-1:0]        den_i,
  output side_t                 side_o,
  output logic [OUT_W-1:0]      corr_o
);

  logic           ocean;
  logic [D_W-1:0] dv;
  logic [N_W-1:0] nv;
  side_t          sd0_nxt;

  side_t          sd0_r, sd1_r;
  logic [N_W-1:0] n0_r, n1_r;
  logic [D_W-1:0] d0_r, d1_r;
  logic           sat1_r;

  logic [N_W-1:0] rem_r [Q_W-1];
  logic [D_W-1:0] dd_r  [Q_W-1];
  logic [Q_W-1:0] q_r   [Q_W];
  logic           sat_r [Q_W];
  side_t          sd_r  [Q_W];

  assign ocean = side_i.cls == OCEAN_CLASS;
  assign dv    = ocean ? den_i : d_of(side_i.cls);
  assign nv    = ocean ? OCEAN_NUM : (N_W'($unsigned(n_i)) << 14);

  always_comb begin
    sd0_nxt = side_i;
    sd0_nxt.zero = !ocean && (n_i[G_W-1] || n_i == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd0_r.valid <= 1'b0;
      sd1_r.valid <= 1'b0;
    end else if (ce) begin
      sd0_r <= sd0_nxt;
      sd1_r <= sd0_r;
    end
  end

  // rounding bias, then saturation test against divisor * 2^16
  always_ff @(posedge clk) begin
    if (ce) begin
      n0_r   <= nv + N_W'(dv >> 1);
      d0_r   <= dv;
      n1_r   <= n0_r;
      d1_r   <= d0_r;
      sat1_r <= n0_r >= {d0_r, 16'b0};
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int I = Q_W - 1 - j;
    logic [N_W-1:0] rc;
    logic [N_W-1:0] term;
    logic [D_W-1:0] dc;
    logic [Q_W-1:0] qc;
    logic           satc;
    side_t          sc;
    logic           take;

    if (j == 0) begin : g_first
      assign rc   = n1_r;
      assign dc   = d1_r;
      assign qc   = '0;
      assign satc = sat1_r;
      assign sc   = sd1_r;
    end else begin : g_next
      assign rc   = rem_r[j-1];
      assign dc   = dd_r[j-1];
      assign qc   = q_r[j-1];
      assign satc = sat_r[j-1];
      assign sc   = sd_r[j-1];
    end

    assign term = N_W'(dc) << I;
    assign take = rc >= term;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[j].valid <= 1'b0;
      end else if (ce) begin
        sd_r[j]  <= sc;
        q_r[j]   <= take ? (qc | (Q_W'(1) << I)) : qc;
        sat_r[j] <= satc;
      end
    end

    if (j < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[j] <= take ? (rc - term) : rc;
          dd_r[j]  <= dc;
        end
      end
    end
  end

  assign side_o = sd_r[Q_W-1];
  assign corr_o = (sd_r[Q_W-1].status != ST_OK || sd_r[Q_W-1].zero) ? '0 :
                  sat_r[Q_W-1] ? '1 : q_r[Q_W-1];

endmodule

/* hw/rtl/surface_albedo_zenith_correction_core.sv */
// Throughput: one beat per cycle while no output beat is held; every stage is a
// register, no loop is shared.
// Depth: 32 square-root stages, 24 CORDIC stages, 7 polynomial stages, 18 divider stages.
// A held output beat freezes the whole pipeline; input stall follows it.
// Reset (rst_n low, synchronous) clears all stage valid bits; data registers are not reset.
`timescale 1ns / 1ps

module surface_albedo_zenith_correction_core
  import sazc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CLS_W-1:0] in_land_class,
  input  logic [COS_W-1:0] in_cos_zenith,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_correction,
  output logic [ST_W-1:0]  out_status
);

  logic                  ce;
  side_t                 in_nxt;
  side_t                 in_r;
  side_t                 sq_side;
  logic [ROOT_W-1:0]     sq_root;
  side_t                 co_side;
  logic signed [ZW-1:0]  co_z;
  side_t                 po_side;
  logic signed [G_W-1:0] po_n;
  logic [D_W-1:0]        po_den;
  side_t                 dv_side;

  assign ce       = !(out_valid && out_stall);
  assign in_stall = !ce;

  always_comb begin
    in_nxt.valid  = in_valid;
    in_nxt.cls    = in_land_class;
    in_nxt.cos    = (in_cos_zenith > COS_ONE) ? '0 : in_cos_zenith;
    in_nxt.zero   = 1'b0;
    in_nxt.status = ST_OK;
    if (in_cos_zenith > COS_ONE) begin
      in_nxt.status = ST_RANGE;
    end else if (in_land_class == '0 || in_land_class > CLS_W'(MAX_CLASS)) begin
      in_nxt.status = ST_CLASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.valid <= 1'b0;
    end else if (ce) begin
      in_r <= in_nxt;
    end
  end

  sazc_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .side_i (in_r),
    .side_o (sq_side),
    .root_o (sq_root)
  );

  sazc_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .side_i (sq_side),
    .root_i (sq_root),
    .side_o (co_side),
    .z_o    (co_z)
  );

  sazc_poly u_poly (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .side_i (co_side),
    .z_i    (co_z),
    .side_o (po_side),
    .n_o    (po_n),
    .den_o  (po_den)
  );

  sazc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .side_i (po_side),
    .n_i    (po_n),
    .den_i  (po_den),
    .side_o (dv_side),
    .corr_o (out_correction)
  );

  assign out_valid  = dv_side.valid;
  assign out_status = dv_side.status;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_correction == '0)
    else $error("error status with nonzero correction");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_CLASS ||
                   out_status == ST_RANGE))
    else $error("undefined status code");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output beat");
`endif

endmodule
